// ===== rtl/sled_pkg.sv =====
// Shared types, scancodes and key tables of the scancode line editor.
`default_nettype none

package sled_pkg;

  localparam int unsigned LINE_DEPTH_DEF     = 128;
  localparam int unsigned TERMINAL_COUNT_DEF = 3;
  localparam int unsigned Q_DEPTH            = 4;

  typedef enum logic [1:0] {
    CMD_KEY   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] SC_ALT_MAKE     = 8'h38;
  localparam logic [7:0] SC_ALT_BREAK    = 8'hB8;
  localparam logic [7:0] SC_CAPS         = 8'h3A;
  localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
  localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
  localparam logic [7:0] SC_SPACE        = 8'h39;
  localparam logic [7:0] SC_BACKSPACE    = 8'h0E;
  localparam logic [7:0] SC_ENTER        = 8'h1C;
  localparam logic [7:0] SC_KEY_L        = 8'h26;
  localparam logic [7:0] SC_F1           = 8'h3B;
  localparam logic [7:0] SC_F3           = 8'h3D;
  localparam logic [7:0] SC_TABLE_FIRST  = 8'h01;
  localparam logic [7:0] SC_TABLE_LAST   = 8'h35;

  localparam logic [6:0] ASCII_SPACE = 7'h20;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_APPEND,
    OP_ERASE,
    OP_ENTER,
    OP_CLS,
    OP_SWITCH,
    OP_READ,
    OP_CLEAR
  } op_kind_e;

  // Work handed from the front to the back: char or read index in arg
  typedef struct packed {
    op_kind_e   kind;
    logic [6:0] arg;
    logic [1:0] target;
  } op_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] scancode;
    logic [6:0] read_index;
  } item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [6:0] echo_char;
    logic       erase;
    logic       clear_screen;
    logic [1:0] switch_to;
    logic [1:0] active_terminal;
    logic [7:0] line_length;
    logic       line_ready;
    logic [6:0] read_data;
  } result_t;

  // Indexed by scancode minus one
  localparam logic [6:0] PLAIN_MAP [53] = '{
    7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
    7'h30, 7'h2D, 7'h3D, 7'h00, 7'h00,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70,
    7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C,
    7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F
  };

  localparam logic [6:0] SHIFTED_MAP [53] = '{
    7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28,
    7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50,
    7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C,
    7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F
  };

  function automatic logic is_letter(input logic [7:0] sc);
    logic hit;
    hit = ((sc >= 8'h10) && (sc <= 8'h19)) || ((sc >= 8'h1E) && (sc <= 8'h26)) ||
          ((sc >= 8'h2C) && (sc <= 8'h32));
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sled_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none

module sled_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/sled_fifo.sv =====
// Small synchronous queue built from registers.
`default_nettype none

module sled_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       wr_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       rd_i,
  output logic      [WIDTH-1:0]           rdata_o,
  output logic                            full_o,
  output logic                            empty_o,
  output logic      [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      count_q <= count_q + CW'(wr_i) - CW'(rd_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !wr_i || rd_i)
    else $error("queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> !empty_o)
    else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== rtl/sled_front.sv =====
// Front end: tracks modifier keys and turns each item into one editor operation.
`default_nettype none

module sled_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire sled_pkg::item_t item_i,
  output sled_pkg::op_t        op_o
);

  import sled_pkg::*;

  logic shift_q, alt_q, ctrl_q, caps_q;
  logic shift_d, alt_d, ctrl_d, caps_d;
  logic sh_n, alt_n, ctrl_n, caps_n;
  logic [7:0] sc;
  logic       in_table;
  logic [5:0] tbl_idx;
  logic       use_shifted;
  logic [6:0] ch;
  logic       is_key;
  op_t        op;

  assign sc       = item_i.scancode;
  assign is_key   = (cmd_e'(item_i.command) == CMD_KEY);
  assign in_table = (sc >= SC_TABLE_FIRST) && (sc <= SC_TABLE_LAST);
  assign tbl_idx  = in_table ? 6'(sc - SC_TABLE_FIRST) : '0;

  always_comb begin
    sh_n   = shift_q;
    alt_n  = alt_q;
    caps_n = caps_q;
    ctrl_n = ctrl_q;
    if (sc == SC_LSHIFT_MAKE || sc == SC_RSHIFT_MAKE) begin
      sh_n = 1'b1;
    end else if (sc == SC_LSHIFT_BREAK || sc == SC_RSHIFT_BREAK) begin
      sh_n = 1'b0;
    end
    case (sc)
      SC_ALT_MAKE:   alt_n  = 1'b1;
      SC_ALT_BREAK:  alt_n  = 1'b0;
      SC_CAPS:       caps_n = !caps_q;
      SC_CTRL_MAKE:  ctrl_n = 1'b1;
      SC_CTRL_BREAK: ctrl_n = 1'b0;
      default: ;
    endcase

    // Caps inverts shift for letters only; other keys ignore shift under caps
    use_shifted = is_letter(sc) ? (caps_n ^ sh_n) : (sh_n & !caps_n);
    ch = use_shifted ? SHIFTED_MAP[tbl_idx] : PLAIN_MAP[tbl_idx];

    op = '{kind: OP_NOP, arg: '0, target: '0};
    case (cmd_e'(item_i.command))
      CMD_KEY: begin
        if (ctrl_n && sc == SC_KEY_L) begin
          op.kind = OP_CLS;
        end else if (alt_n && (sc inside {[SC_F1:SC_F3]})) begin
          op.kind   = OP_SWITCH;
          op.target = 2'(sc - SC_F1 + 8'd1);
        end else if (sc == SC_SPACE) begin
          op.kind = OP_APPEND;
          op.arg  = ASCII_SPACE;
        end else if (sc == SC_BACKSPACE) begin
          // the back drops this on an empty line
          op.kind = OP_ERASE;
        end else if (sc == SC_ENTER) begin
          op.kind = OP_ENTER;
        end else if (in_table && ch != '0) begin
          op.kind = OP_APPEND;
          op.arg  = ch;
        end
      end
      CMD_READ: begin
        op.kind = OP_READ;
        op.arg  = item_i.read_index;
      end
      CMD_CLEAR: op.kind = OP_CLEAR;
      default: ;
    endcase

    shift_d = shift_q;
    alt_d   = alt_q;
    ctrl_d  = ctrl_q;
    caps_d  = caps_q;
    if (accept_i && is_key) begin
      shift_d = sh_n;
      alt_d   = alt_n;
      ctrl_d  = ctrl_n;
      caps_d  = caps_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      alt_q   <= 1'b0;
      ctrl_q  <= 1'b0;
      caps_q  <= 1'b0;
    end else begin
      shift_q <= shift_d;
      alt_q   <= alt_d;
      ctrl_q  <= ctrl_d;
      caps_q  <= caps_d;
    end
  end

  assign op_o = op;

endmodule

`default_nettype wire

// ===== rtl/sled_back.sv =====
// Back end: applies operations to the terminal lines and builds the results.
`default_nettype none

module sled_back #(
  parameter int unsigned LINE_DEPTH     = sled_pkg::LINE_DEPTH_DEF,
  parameter int unsigned TERMINAL_COUNT = sled_pkg::TERMINAL_COUNT_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             op_valid_i,
  input  wire sled_pkg::op_t    op_i,
  input  wire logic             room_i,
  output logic                  op_take_o,
  output logic                  res_valid_o,
  output sled_pkg::result_t     res_o
);

  import sled_pkg::*;

  localparam int unsigned LEN_W     = $clog2(LINE_DEPTH + 1);
  localparam int unsigned SLOT_W    = (TERMINAL_COUNT > 1) ? $clog2(TERMINAL_COUNT) : 1;
  localparam int unsigned RAM_DEPTH = TERMINAL_COUNT * LINE_DEPTH;
  localparam int unsigned AW        = $clog2(RAM_DEPTH);
  localparam int unsigned CMP_W     = (LEN_W > 7) ? LEN_W : 7;

  logic [1:0]       term_q, term_d;
  logic [LEN_W-1:0] len_q [TERMINAL_COUNT];
  logic [LEN_W-1:0] act_len_q, act_len_d;
  logic             ready_q, ready_d;
  logic             b_valid_q, b_rd_q;
  result_t          b_res_q;

  logic             fire;
  logic [SLOT_W-1:0] slot, tgt_slot;
  logic             sw_hit, rd, ram_we;
  logic [AW-1:0]    pos, ram_addr;
  logic [6:0]       ram_rdata;
  result_t          res_d;

  assign fire      = op_valid_i && room_i;
  assign op_take_o = fire;
  assign slot      = SLOT_W'(term_q - 2'd1);
  assign tgt_slot  = SLOT_W'(op_i.target - 2'd1);

  always_comb begin
    term_d    = term_q;
    act_len_d = act_len_q;
    ready_d   = ready_q;
    sw_hit    = 1'b0;
    rd        = 1'b0;
    ram_we    = 1'b0;
    pos       = AW'(act_len_q);
    res_d     = '0;
    if (fire) begin
      case (op_i.kind)
        OP_APPEND: begin
          if (act_len_q < LEN_W'(LINE_DEPTH)) begin
            ram_we          = 1'b1;
            act_len_d       = act_len_q + LEN_W'(1);
            res_d.echo_valid = 1'b1;
            res_d.echo_char  = op_i.arg;
          end
        end
        OP_ERASE: begin
          if (act_len_q != '0) begin
            act_len_d   = act_len_q - LEN_W'(1);
            res_d.erase = 1'b1;
          end
        end
        OP_ENTER: ready_d = 1'b1;
        OP_CLS:   res_d.clear_screen = 1'b1;
        OP_SWITCH: begin
          if (op_i.target != term_q && op_i.target <= 2'(TERMINAL_COUNT)) begin
            sw_hit          = 1'b1;
            term_d          = op_i.target;
            act_len_d       = len_q[tgt_slot];
            res_d.switch_to = op_i.target;
          end
        end
        OP_READ: begin
          rd  = (CMP_W'(op_i.arg) < CMP_W'(act_len_q));
          pos = AW'(op_i.arg);
        end
        OP_CLEAR: begin
          act_len_d = '0;
          ready_d   = 1'b0;
        end
        default: ;
      endcase
    end
    res_d.active_terminal = term_d;
    res_d.line_length     = 8'(act_len_d);
    res_d.line_ready      = ready_d;
  end

  assign ram_addr = AW'(slot) * AW'(LINE_DEPTH) + pos;

  sled_ram #(
    .WIDTH (7),
    .DEPTH (RAM_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (op_i.arg),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q    <= 2'd1;
      act_len_q <= '0;
      ready_q   <= 1'b0;
      b_valid_q <= 1'b0;
      for (int i = 0; i < TERMINAL_COUNT; i++) begin
        len_q[i] <= '0;
      end
    end else begin
      b_valid_q <= fire;
      if (fire) begin
        term_q    <= term_d;
        act_len_q <= act_len_d;
        ready_q   <= ready_d;
        // keep the stored length of the line being left in step
        len_q[slot] <= sw_hit ? act_len_q : act_len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    b_res_q <= res_d;
    b_rd_q  <= rd;
  end

  always_comb begin
    res_o           = b_res_q;
    res_o.read_data = b_rd_q ? ram_rdata : '0;
  end
  assign res_valid_o = b_valid_q;

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_len_q <= LEN_W'(LINE_DEPTH))
    else $error("active line length beyond line depth");

  a_term_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_q >= 2'd1 && term_q <= 2'(TERMINAL_COUNT))
    else $error("active terminal out of range");

  a_len_mirror : assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_len_q == len_q[slot])
    else $error("active length and stored length disagree");

endmodule

`default_nettype wire

// ===== rtl/scancode_to_ascii_line_editor_top.sv =====
// Top level of the scancode line editor: front, operation queue, back, result queue.
`default_nettype none

// Takes set-1 scancodes, read and clear commands, one per cycle while full is
// low, and gives one result per item in order. Sustained rate is one item per
// clock while results are popped; an item's result passes through the operation
// queue and the line-store access, whose single port serves either the append
// write or the registered read of an item, and then enters the result queue.
// The front holds the shift, ctrl, alt and caps state; the back holds the
// active terminal, the line lengths, the ready flag and the line store. Both
// queues are four deep, so either side may stall without holding up the other
// until a queue fills. Line store contents start undefined; only positions
// below a line's length are ever read back.
module scancode_to_ascii_line_editor_top #(
  parameter int unsigned LINE_DEPTH     = sled_pkg::LINE_DEPTH_DEF,
  parameter int unsigned TERMINAL_COUNT = sled_pkg::TERMINAL_COUNT_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire sled_pkg::item_t  item_i,
  output logic                  empty,
  input  wire logic             pop,
  output sled_pkg::result_t     result_o
);

  import sled_pkg::*;

  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  logic       accept;
  op_t        op_in, op_out;
  logic       op_empty, op_take;
  logic [CNT_W-1:0] op_count;
  logic       res_valid, res_full, res_room;
  result_t    res_in;
  logic [CNT_W-1:0] res_count;

  assign accept = push && !full;

  sled_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .op_o     (op_in)
  );

  sled_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (Q_DEPTH)
  ) u_op_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .wdata_i (op_in),
    .rd_i    (op_take),
    .rdata_o (op_out),
    .full_o  (full),
    .empty_o (op_empty),
    .count_o (op_count)
  );

  // Leave space for the result already in the line-store stage
  assign res_room = (res_count <= CNT_W'(Q_DEPTH - 2)) && (op_count != '0);

  sled_back #(
    .LINE_DEPTH     (LINE_DEPTH),
    .TERMINAL_COUNT (TERMINAL_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (!op_empty),
    .op_i        (op_out),
    .room_i      (res_room),
    .op_take_o   (op_take),
    .res_valid_o (res_valid),
    .res_o       (res_in)
  );

  sled_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (Q_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_valid),
    .wdata_i (res_in),
    .rd_i    (pop && !empty),
    .rdata_o (result_o),
    .full_o  (res_full),
    .empty_o (empty),
    .count_o (res_count)
  );

  a_res_space : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !res_full)
    else $error("result produced with no space in result queue");

endmodule

`default_nettype wire
